>>> hdl/kpsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsf_pkg: shared constants, types and functions of the k-mer score filter
// Matrix geometry, field widths, configuration register indexes and the
// digit-extraction step used by the shared divider.
// ----------------------------------------------------------------------------
package kpsf_pkg;

  localparam int MAX_LETTERS     = 36;
  localparam int MAX_KMER_LENGTH = 7;

  localparam int LETTER_W = 6;
  localparam int LEN_W    = 3;
  localparam int KMER_W   = 37;
  localparam int SCORE_W  = 16;

  localparam int MAT_DEPTH = MAX_LETTERS * MAX_LETTERS;
  localparam int ADDR_W    = $clog2(MAT_DEPTH);

  // The divider takes CHUNK_W dividend bits per cycle.
  localparam int CHUNK_W   = 8;
  localparam int DIV_STEPS = (KMER_W + CHUNK_W - 1) / CHUNK_W;
  localparam int DIV_W     = DIV_STEPS * CHUNK_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = KMER_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_KMER    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCORE     = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SCORE = 1'b1;

  localparam int IN_DATA_W  = ((2 * LETTER_W + SCORE_W + KMER_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KMER_W + SCORE_W + 7) / 8) * 8;

  typedef struct packed {
    logic [LETTER_W-1:0] rem;
    logic [CHUNK_W-1:0]  quo;
  } div_res_t;

  // Restoring division of a running remainder and CHUNK_W fresh dividend
  // bits by the alphabet size. The remainder always stays below the base.
  function automatic div_res_t div_step(input logic [LETTER_W-1:0] rem,
                                        input logic [CHUNK_W-1:0]  chunk,
                                        input logic [LETTER_W-1:0] base);
    logic [LETTER_W:0] r;
    div_res_t          res;
    r   = {1'b0, rem};
    res = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      r = {r[LETTER_W-1:0], chunk[i]};
      if (r >= {1'b0, base}) begin
        r          = r - {1'b0, base};
        res.quo[i] = 1'b1;
      end
    end
    res.rem = r[LETTER_W-1:0];
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] mat_addr(input logic [LETTER_W-1:0] row,
                                                 input logic [LETTER_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_LETTERS) + ADDR_W'(col);
  endfunction

endpackage

>>> hdl/kmer_pair_score_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_pair_score_filter: substitution-score filter for candidate k-mers
// Holds a letter-pair score matrix and passes on candidates whose summed
// pair score against the configured query reaches the threshold.
// ----------------------------------------------------------------------------
// Usage: a word on the in_ channel with in_tuser low writes one matrix entry
// and leaves the block idle and ready. A word with in_tuser high brings a
// candidate k-mer; the block splits query and candidate into letters with one
// shared divider that handles eight dividend bits per cycle. A candidate
// keeps in_tready low while the divider splits it into letters and through
// the registered read of the matrix memory that follows each letter, until
// its score is ready to be emitted.
// A candidate whose score reaches min_score appears on out_ with its score;
// one below the threshold gives no word. The output register holds its word
// while out_tready is low, and the block may take further words meanwhile;
// a scored candidate waits for the output register to empty before the
// block turns ready again. Reset restores the configuration registers to
// their defaults and clears the control state; the matrix is not cleared
// and has to be written before it is read. Configuration is to be written
// through cfg_ only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module kmer_pair_score_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [kpsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kpsf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // row_letter[5:0], col_letter[11:6], entry_value[27:12],
  // candidate_kmer[64:28], zero padding above
  input  logic [kpsf_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // neighbor_kmer[36:0], pair_score[52:37], zero padding above
  output logic [kpsf_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int LW = kpsf_pkg::LETTER_W;
  localparam int KW = kpsf_pkg::KMER_W;
  localparam int SW = kpsf_pkg::SCORE_W;
  localparam int DW = kpsf_pkg::DIV_W;
  localparam int CW = kpsf_pkg::CHUNK_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // Configuration registers
  logic [LW-1:0]                   alphabet_size_r;
  logic [kpsf_pkg::LEN_W-1:0]      kmer_length_r;
  logic [KW-1:0]                   query_kmer_r;
  logic [SW-1:0]                   min_score_r;

  logic [1:0]                      state_r, state_nxt;
  logic [kpsf_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [kpsf_pkg::LEN_W-1:0]      digit_r, digit_nxt;
  logic [LW-1:0]                   base_r, base_nxt;
  logic [DW-1:0]                   dq_r, dq_nxt;
  logic [DW-1:0]                   dc_r, dc_nxt;
  logic [LW-1:0]                   rq_r, rq_nxt;
  logic [LW-1:0]                   rc_r, rc_nxt;
  logic [LW-1:0]                   lq_r, lq_nxt;
  logic [LW-1:0]                   lc_r, lc_nxt;
  logic                            rd_req_r, rd_req_nxt;
  logic                            acc_req_r;
  logic [SW-1:0]                   mem_q_r;
  logic [SW-1:0]                   sum_r, sum_nxt;
  logic [KW-1:0]                   cand_r, cand_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [KW-1:0]                   out_kmer_r, out_kmer_nxt;
  logic [SW-1:0]                   out_score_r, out_score_nxt;

  logic [SW-1:0]                   score_matrix [kpsf_pkg::MAT_DEPTH];

  logic                            in_fire;
  logic [LW-1:0]                   wr_row;
  logic [LW-1:0]                   wr_col;
  logic [SW-1:0]                   wr_value;
  logic [KW-1:0]                   in_cand;
  logic                            mat_wr;
  logic [LW-1:0]                   base_clamped;
  kpsf_pkg::div_res_t              res_q, res_c;

  assign wr_row   = in_tdata[LW-1:0];
  assign wr_col   = in_tdata[2*LW-1:LW];
  assign wr_value = in_tdata[2*LW+SW-1:2*LW];
  assign in_cand  = in_tdata[2*LW+SW+KW-1:2*LW+SW];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign mat_wr    = in_fire && (in_tuser == kpsf_pkg::MODE_WRITE) &&
                     (wr_row < LW'(kpsf_pkg::MAX_LETTERS)) &&
                     (wr_col < LW'(kpsf_pkg::MAX_LETTERS));

  always_comb begin
    if (alphabet_size_r == '0) begin
      base_clamped = LW'(1);
    end else if (alphabet_size_r > LW'(kpsf_pkg::MAX_LETTERS)) begin
      base_clamped = LW'(kpsf_pkg::MAX_LETTERS);
    end else begin
      base_clamped = alphabet_size_r;
    end
  end

  // Both lanes of the shared divider work on the top chunk of their dividend.
  assign res_q = kpsf_pkg::div_step(rq_r, dq_r[DW-1:DW-CW], base_r);
  assign res_c = kpsf_pkg::div_step(rc_r, dc_r[DW-1:DW-CW], base_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alphabet_size_r <= LW'(kpsf_pkg::MAX_LETTERS);
      kmer_length_r   <= kpsf_pkg::LEN_W'(5);
      query_kmer_r    <= '0;
      min_score_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        kpsf_pkg::CFG_ALPHABET_SIZE: alphabet_size_r <= cfg_wdata[LW-1:0];
        kpsf_pkg::CFG_KMER_LENGTH:   kmer_length_r   <= cfg_wdata[kpsf_pkg::LEN_W-1:0];
        kpsf_pkg::CFG_QUERY_KMER:    query_kmer_r    <= cfg_wdata[KW-1:0];
        kpsf_pkg::CFG_MIN_SCORE:     min_score_r     <= cfg_wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mat_wr) begin
      score_matrix[kpsf_pkg::mat_addr(wr_row, wr_col)] <= wr_value;
    end
    if (rd_req_r) begin
      mem_q_r <= score_matrix[kpsf_pkg::mat_addr(lq_r, lc_r)];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    digit_nxt     = digit_r;
    base_nxt      = base_r;
    dq_nxt        = dq_r;
    dc_nxt        = dc_r;
    rq_nxt        = rq_r;
    rc_nxt        = rc_r;
    lq_nxt        = lq_r;
    lc_nxt        = lc_r;
    rd_req_nxt    = 1'b0;
    sum_nxt       = sum_r;
    cand_nxt      = cand_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kmer_nxt  = out_kmer_r;
    out_score_nxt = out_score_r;

    if (acc_req_r) begin
      sum_nxt = sum_r + mem_q_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == kpsf_pkg::MODE_SCORE)) begin
          base_nxt  = base_clamped;
          dq_nxt    = DW'(query_kmer_r);
          dc_nxt    = DW'(in_cand);
          rq_nxt    = '0;
          rc_nxt    = '0;
          step_nxt  = '0;
          digit_nxt = '0;
          sum_nxt   = '0;
          cand_nxt  = in_cand;
          state_nxt = (kmer_length_r == '0) ? ST_DRAIN : ST_DIV;
        end
      end
      ST_DIV: begin
        dq_nxt = {dq_r[DW-CW-1:0], res_q.quo};
        dc_nxt = {dc_r[DW-CW-1:0], res_c.quo};
        if (step_r == kpsf_pkg::STEP_W'(kpsf_pkg::DIV_STEPS - 1)) begin
          // The remainders are the next pair of letters; the quotients left
          // in the shift registers are the dividends for the following pair.
          lq_nxt     = res_q.rem;
          lc_nxt     = res_c.rem;
          rd_req_nxt = 1'b1;
          rq_nxt     = '0;
          rc_nxt     = '0;
          step_nxt   = '0;
          if (digit_r == kmer_length_r - kpsf_pkg::LEN_W'(1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            digit_nxt = digit_r + kpsf_pkg::LEN_W'(1);
          end
        end else begin
          rq_nxt   = res_q.rem;
          rc_nxt   = res_c.rem;
          step_nxt = step_r + kpsf_pkg::STEP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_req_r && !acc_req_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          if ($signed(sum_r) >= $signed(min_score_r)) begin
            out_valid_nxt = 1'b1;
            out_kmer_nxt  = cand_r;
            out_score_nxt = sum_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_req_r    <= 1'b0;
      acc_req_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_req_r    <= rd_req_nxt;
      acc_req_r   <= rd_req_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    digit_r     <= digit_nxt;
    base_r      <= base_nxt;
    dq_r        <= dq_nxt;
    dc_r        <= dc_nxt;
    rq_r        <= rq_nxt;
    rc_r        <= rc_nxt;
    lq_r        <= lq_nxt;
    lc_r        <= lc_nxt;
    sum_r       <= sum_nxt;
    cand_r      <= cand_nxt;
    out_kmer_r  <= out_kmer_nxt;
    out_score_r <= out_score_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(kpsf_pkg::OUT_DATA_W - KW - SW){1'b0}}, out_score_r, out_kmer_r};

endmodule

>>> sim/kmer_pair_score_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_pair_score_filter_tb: self-checking bench for the k-mer score filter
// Loads substitution scores, scores candidate k-mers against the configured
// query under several alphabet sizes, lengths and thresholds, and compares
// every emitted neighbour with an in-bench scorer. Both stream sides idle at
// random; matrix entries are always written before any candidate reads them.
// ----------------------------------------------------------------------------
module kmer_pair_score_filter_tb;

  localparam int     IDLE_CYCLES  = 64;
  localparam int     RANDOM_ITEMS = 1300;
  // Slowest correct run: a few thousand words, each behind the longest
  // sender gap, then scored, then held by the longest receiver stall.
  localparam longint CYCLE_LIMIT  = 2_000_000;

  localparam logic [kpsf_pkg::KMER_W-1:0]  KMER_ALL   = '1;
  localparam logic [kpsf_pkg::KMER_W-1:0]  KMER_TOP   = 37'd78364164095;
  localparam logic [kpsf_pkg::SCORE_W-1:0] SCORE_MAX  = 16'h7FFF;
  localparam logic [kpsf_pkg::SCORE_W-1:0] SCORE_MIN  = 16'h8000;
  localparam logic [kpsf_pkg::SCORE_W-1:0] SCORE_ZERO = 16'h0000;

  typedef struct packed {
    logic [kpsf_pkg::KMER_W-1:0]  kmer;
    logic [kpsf_pkg::SCORE_W-1:0] score;
  } neighbour_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_wr_en  = 1'b0;
  logic [kpsf_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [kpsf_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [kpsf_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [kpsf_pkg::OUT_DATA_W-1:0] out_tdata;

  // Bench copy of the configuration and of the substitution matrix.
  logic [kpsf_pkg::LETTER_W-1:0] alpha_reg = 6'd36;
  logic [kpsf_pkg::LEN_W-1:0]    klen_reg  = 3'd5;
  logic [kpsf_pkg::KMER_W-1:0]   query_reg = '0;
  logic [kpsf_pkg::SCORE_W-1:0]  min_reg   = '0;
  logic [kpsf_pkg::SCORE_W-1:0]  subst
    [kpsf_pkg::MAX_LETTERS][kpsf_pkg::MAX_LETTERS];
  bit                            subst_known
    [kpsf_pkg::MAX_LETTERS][kpsf_pkg::MAX_LETTERS];

  neighbour_t hit_queue[$];
  int         mismatches  = 0;
  int         words_sent  = 0;
  longint     cycle_count = 0;
  bit         tx_quiet    = 1'b0;
  bit         rx_quiet    = 1'b0;

  kmer_pair_score_filter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [kpsf_pkg::KMER_W-1:0] rand_kmer();
    return kpsf_pkg::KMER_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [kpsf_pkg::SCORE_W-1:0] rand_entry();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SCORE_MAX;
    if (r == 1) return SCORE_MIN;
    return kpsf_pkg::SCORE_W'($urandom());
  endfunction

  function automatic logic [kpsf_pkg::LETTER_W-1:0] rand_letter();
    if ($urandom_range(0, 9) == 0) return kpsf_pkg::LETTER_W'($urandom_range(36, 63));
    return kpsf_pkg::LETTER_W'($urandom_range(0, kpsf_pkg::MAX_LETTERS - 1));
  endfunction

  // Zero acts as a base of one, anything beyond the matrix as its full size.
  function automatic longint unsigned letter_base();
    if (alpha_reg == 0) return 1;
    if (alpha_reg > kpsf_pkg::MAX_LETTERS) return kpsf_pkg::MAX_LETTERS;
    return alpha_reg;
  endfunction

  function automatic int letter_count();
    if (klen_reg > kpsf_pkg::MAX_KMER_LENGTH) return kpsf_pkg::MAX_KMER_LENGTH;
    return klen_reg;
  endfunction

  function automatic logic [kpsf_pkg::SCORE_W-1:0] calc_pair_score(
      input logic [kpsf_pkg::KMER_W-1:0] cand);
    longint unsigned              q, c, base;
    logic [kpsf_pkg::SCORE_W-1:0] sum;
    base = letter_base();
    q    = query_reg;
    c    = cand;
    sum  = '0;
    for (int i = 0; i < letter_count(); i++) begin
      sum = sum + subst[q % base][c % base];
      q   = q / base;
      c   = c / base;
    end
    return sum;
  endfunction

  task automatic send_word(input logic mode,
                           input logic [kpsf_pkg::LETTER_W-1:0] row,
                           input logic [kpsf_pkg::LETTER_W-1:0] col,
                           input logic [kpsf_pkg::SCORE_W-1:0]  val,
                           input logic [kpsf_pkg::KMER_W-1:0]   cand);
    int                           gap;
    neighbour_t                   hit;
    logic [kpsf_pkg::SCORE_W-1:0] s;
    gap = pick_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = mode;
    in_tdata  = kpsf_pkg::IN_DATA_W'({cand, val, col, row});
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (mode == kpsf_pkg::MODE_WRITE) begin
      if (row < kpsf_pkg::MAX_LETTERS && col < kpsf_pkg::MAX_LETTERS) begin
        subst[row][col]       = val;
        subst_known[row][col] = 1'b1;
      end
    end else begin
      s = calc_pair_score(cand);
      if ($signed(s) >= $signed(min_reg)) begin
        hit.kmer  = cand;
        hit.score = s;
        hit_queue = {hit_queue, hit};
      end
    end
  endtask

  // Any letter pair the candidate will touch that has never been loaded gets
  // a fresh entry first, so the block never reads an unwritten word.
  task automatic score_kmer(input logic [kpsf_pkg::KMER_W-1:0] cand);
    longint unsigned               q, c, base;
    logic [kpsf_pkg::LETTER_W-1:0] lq, lc;
    base = letter_base();
    q    = query_reg;
    c    = cand;
    for (int i = 0; i < letter_count(); i++) begin
      lq = kpsf_pkg::LETTER_W'(q % base);
      lc = kpsf_pkg::LETTER_W'(c % base);
      if (!subst_known[lq][lc]) begin
        send_word(kpsf_pkg::MODE_WRITE, lq, lc, rand_entry(), rand_kmer());
      end
      q = q / base;
      c = c / base;
    end
    send_word(kpsf_pkg::MODE_SCORE, kpsf_pkg::LETTER_W'($urandom()),
              kpsf_pkg::LETTER_W'($urandom()), rand_entry(), cand);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [kpsf_pkg::LETTER_W-1:0] alpha,
                            input logic [kpsf_pkg::LEN_W-1:0]    klen,
                            input logic [kpsf_pkg::KMER_W-1:0]   query,
                            input logic [kpsf_pkg::SCORE_W-1:0]  mins);
    drain();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = kpsf_pkg::CFG_ALPHABET_SIZE;
    cfg_wdata = kpsf_pkg::CFG_DATA_W'(alpha);
    @(negedge clk);
    cfg_index = kpsf_pkg::CFG_KMER_LENGTH;
    cfg_wdata = kpsf_pkg::CFG_DATA_W'(klen);
    @(negedge clk);
    cfg_index = kpsf_pkg::CFG_QUERY_KMER;
    cfg_wdata = kpsf_pkg::CFG_DATA_W'(query);
    @(negedge clk);
    cfg_index = kpsf_pkg::CFG_MIN_SCORE;
    cfg_wdata = kpsf_pkg::CFG_DATA_W'(mins);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    alpha_reg = alpha;
    klen_reg  = klen;
    query_reg = query;
    min_reg   = mins;
  endtask

  always @(posedge clk) begin : check_out
    neighbour_t exp_hit;
    if (rst_n && out_tvalid && out_tready) begin
      if (hit_queue.size() == 0) begin
        $error("neighbor_kmer mismatch: expected none, actual %0d",
               out_tdata[kpsf_pkg::KMER_W-1:0]);
        mismatches++;
      end else begin
        exp_hit = hit_queue.pop_front();
        if (out_tdata[kpsf_pkg::KMER_W-1:0] !== exp_hit.kmer) begin
          $error("neighbor_kmer mismatch: expected %0d, actual %0d", exp_hit.kmer,
                 out_tdata[kpsf_pkg::KMER_W-1:0]);
          mismatches++;
        end
        if (out_tdata[kpsf_pkg::KMER_W+kpsf_pkg::SCORE_W-1:kpsf_pkg::KMER_W] !==
            exp_hit.score) begin
          $error("pair_score mismatch: expected %0d, actual %0d", $signed(exp_hit.score),
                 $signed(out_tdata[kpsf_pkg::KMER_W+kpsf_pkg::SCORE_W-1:kpsf_pkg::KMER_W]));
          mismatches++;
        end
      end
    end
  end

  initial begin : rx_stall
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        stall      = pick_gap(rx_quiet);
      end
    end
  end

  // Defaults after reset: alphabet of 36, five letters, query zero, threshold 0.
  task automatic test_reset_defaults();
    send_word(kpsf_pkg::MODE_WRITE, 6'd0, 6'd0, 16'd7, '0);
    send_word(kpsf_pkg::MODE_WRITE, 6'd0, 6'd1, 16'hFFFD, '0);
    score_kmer('0);
    score_kmer(37'd1);
  endtask

  task automatic test_write_extremes();
    send_word(kpsf_pkg::MODE_WRITE, 6'd35, 6'd35, SCORE_MAX, KMER_ALL);
    send_word(kpsf_pkg::MODE_WRITE, 6'd35, 6'd0, SCORE_MIN, KMER_ALL);
    send_word(kpsf_pkg::MODE_WRITE, 6'd0, 6'd35, 16'hFFFF, '0);
    // Letters beyond the matrix must be dropped.
    send_word(kpsf_pkg::MODE_WRITE, 6'd36, 6'd0, SCORE_MAX, '0);
    send_word(kpsf_pkg::MODE_WRITE, 6'd0, 6'd36, SCORE_MAX, '0);
    send_word(kpsf_pkg::MODE_WRITE, 6'd63, 6'd63, SCORE_MIN, KMER_ALL);
    set_config(6'd36, 3'd7, KMER_TOP, SCORE_MIN);
    score_kmer(KMER_TOP);
    score_kmer('0);
  endtask

  task automatic test_score_wrap();
    set_config(6'd36, 3'd2, '0, SCORE_ZERO);
    send_word(kpsf_pkg::MODE_WRITE, 6'd0, 6'd0, SCORE_MAX, '0);
    score_kmer('0);
    set_config(6'd36, 3'd2, '0, 16'hFFFE);
    score_kmer('0);
    send_word(kpsf_pkg::MODE_WRITE, 6'd0, 6'd0, SCORE_MIN, '0);
    score_kmer('0);
  endtask

  task automatic test_oversized_kmer();
    set_config(6'd36, 3'd3, KMER_ALL, SCORE_MIN);
    score_kmer(KMER_ALL);
    score_kmer(rand_kmer());
  endtask

  task automatic test_alphabet_limits();
    set_config(6'd0, 3'd7, KMER_ALL, SCORE_MIN);
    score_kmer(KMER_ALL);
    set_config(6'd1, 3'd3, rand_kmer(), SCORE_MIN);
    score_kmer(rand_kmer());
    set_config(6'd63, 3'd4, rand_kmer(), SCORE_MIN);
    score_kmer(KMER_ALL);
    set_config(6'd20, 3'd7, rand_kmer(), SCORE_ZERO);
    score_kmer(rand_kmer());
  endtask

  task automatic test_zero_length();
    set_config(6'd36, 3'd0, rand_kmer(), SCORE_ZERO);
    score_kmer(rand_kmer());
    set_config(6'd36, 3'd0, rand_kmer(), 16'd1);
    score_kmer(rand_kmer());
  endtask

  // Every word counts towards the budget, the matrix fills as well.
  task automatic test_random_traffic();
    int                            first, n, r;
    logic [kpsf_pkg::LETTER_W-1:0] alpha;
    logic [kpsf_pkg::LEN_W-1:0]    klen;
    logic [kpsf_pkg::KMER_W-1:0]   query;
    logic [kpsf_pkg::SCORE_W-1:0]  mins;
    logic [kpsf_pkg::KMER_W-1:0]   cand;
    first = words_sent;
    while (words_sent - first < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) alpha = kpsf_pkg::LETTER_W'($urandom_range(0, 1));
      else if (r == 1) alpha = kpsf_pkg::LETTER_W'($urandom_range(37, 63));
      else if (r == 2) alpha = 6'd20;
      else if (r == 3) alpha = 6'd36;
      else alpha = kpsf_pkg::LETTER_W'($urandom_range(20, 36));
      if ($urandom_range(0, 9) == 0) klen = kpsf_pkg::LEN_W'($urandom_range(0, 1));
      else klen = kpsf_pkg::LEN_W'($urandom_range(2, 7));
      r = $urandom_range(0, 7);
      if (r == 0) query = KMER_ALL;
      else if (r == 1) query = '0;
      else if (r == 2) query = KMER_TOP;
      else query = rand_kmer();
      r = $urandom_range(0, 9);
      if (r == 0) mins = SCORE_MIN;
      else if (r == 1) mins = SCORE_MAX;
      else if (r == 2) mins = SCORE_ZERO;
      else if (r < 5) mins = kpsf_pkg::SCORE_W'($urandom_range(0, 4000) - 2000);
      else mins = kpsf_pkg::SCORE_W'($urandom());
      set_config(alpha, klen, query, mins);
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      n = $urandom_range(60, 140);
      for (int k = 0; k < n && words_sent - first < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_word(kpsf_pkg::MODE_WRITE, rand_letter(), rand_letter(), rand_entry(),
                    rand_kmer());
        end else begin
          r = $urandom_range(0, 19);
          if (r == 0) cand = KMER_ALL;
          else if (r == 1) cand = '0;
          else if (r == 2) cand = query_reg;
          else if (r == 3) cand = KMER_TOP;
          else cand = rand_kmer();
          score_kmer(cand);
        end
        // Now and then let every outstanding neighbour come out before going on.
        if ($urandom_range(0, 199) == 0) drain();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_write_extremes();
    test_score_wrap();
    test_oversized_kmer();
    test_alphabet_limits();
    test_zero_length();
    test_random_traffic();
    drain();
    if (mismatches == 0 && hit_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
